// ===== rtl/fcv_pkg.sv =====
package fcv_pkg;

	// Datapath geometry.
	localparam int MAX_TAPS = 6;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH = 16;
	localparam int COEF_REGS = 6;
	localparam int RESULT_WIDTH = 34;
	localparam int TAP_COUNT_WIDTH = 3;
	localparam int TAPS_W = $clog2(MAX_TAPS + 1);
	localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_W = (PROD_W + 3 > RESULT_WIDTH) ? PROD_W + 3 : RESULT_WIDTH;
	localparam int HALF_TAPS = (MAX_TAPS + 1) / 2;

	// Queue depths; both are powers of two so the pointers wrap on their own.
	localparam int IN_DEPTH = 4;
	localparam int IN_PTR_W = $clog2(IN_DEPTH);
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

	// Configuration register map.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COEF_FIRST = 3'd1;
	localparam logic [TAP_COUNT_WIDTH-1:0] TAP_COUNT_RESET = 3'd3;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last;
	} item_t;

	typedef struct packed {
		logic signed [RESULT_WIDTH-1:0] value;
		logic                           last;
	} res_t;

	typedef struct packed {
		logic                   valid;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

	// Effective tap count: zero counts as one, large values clamp to the maximum.
	function automatic logic [TAPS_W-1:0] taps_in_use(input logic [TAP_COUNT_WIDTH-1:0] tc);
		logic [TAPS_W-1:0] t;
		begin
			if (tc == '0) begin
				t = TAPS_W'(1);
			end else if (int'(tc) > MAX_TAPS) begin
				t = TAPS_W'(MAX_TAPS);
			end else begin
				t = TAPS_W'(tc);
			end
			return t;
		end
	endfunction

endpackage

// ===== rtl/fcv_front.sv =====
module fcv_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  fcv_pkg::item_t   item,
	output fcv_pkg::item_t   head,
	output logic             head_valid,
	input  logic             head_pop
);

	fcv_pkg::item_t                   mem_q [fcv_pkg::IN_DEPTH];
	logic [fcv_pkg::IN_PTR_W-1:0]     wr_ptr_q;
	logic [fcv_pkg::IN_PTR_W-1:0]     rd_ptr_q;
	logic [fcv_pkg::IN_PTR_W:0]       count_q;
	logic                             wr_en;
	logic                             rd_en;

	// Input transfer and hand-off to the back end.
	assign full = (count_q == (fcv_pkg::IN_PTR_W + 1)'(fcv_pkg::IN_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign wr_en = push && !full;
	assign rd_en = head_pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/fcv_back.sv =====
module fcv_back (
	input  logic             clk,
	input  logic             arst_n,
	input  fcv_pkg::cfg_wr_t cfg,
	input  fcv_pkg::item_t   head,
	input  logic             head_valid,
	output logic             head_pop,
	input  logic             out_pop,
	output logic             res_valid,
	output fcv_pkg::res_t    res
);

	localparam int SW = fcv_pkg::SAMPLE_WIDTH;
	localparam int NT = fcv_pkg::MAX_TAPS;
	localparam int TW = fcv_pkg::TAPS_W;
	localparam int PW = fcv_pkg::PROD_W;
	localparam int AW = fcv_pkg::ACC_W;
	localparam int NH = fcv_pkg::HALF_TAPS;
	localparam int CW = fcv_pkg::OUT_PTR_W + 1;

	logic [fcv_pkg::TAP_COUNT_WIDTH-1:0]        tap_count_q;
	logic signed [fcv_pkg::COEF_WIDTH-1:0]      coef_q [fcv_pkg::COEF_REGS];
	logic signed [SW-1:0]                       dl_q [NT-1];
	logic [TW-1:0]                              tail_q;
	logic [CW-1:0]                              outst_q;

	logic [TW-1:0]                              taps;
	logic                                       in_tail;
	logic                                       room;
	logic                                       issue;
	logic                                       blk_end;
	logic                                       start_tail;
	logic signed [SW-1:0]                       cur;
	logic signed [SW-1:0]                       window [NT];
	logic signed [PW-1:0]                       prod [NT];

	logic                                       valid_s1;
	logic                                       last_s1;
	logic signed [PW-1:0]                       prod_s1 [NT];
	logic                                       valid_s2;
	logic                                       last_s2;
	logic signed [AW-1:0]                       psum_s2 [NH];
	logic signed [AW-1:0]                       total;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fcv_pkg::TAP_COUNT_RESET;
			for (int k = 0; k < fcv_pkg::COEF_REGS; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg.valid) begin
			if (cfg.index == fcv_pkg::CFG_TAP_COUNT) begin
				tap_count_q <= cfg.data[fcv_pkg::TAP_COUNT_WIDTH-1:0];
			end
			for (int k = 0; k < fcv_pkg::COEF_REGS; k++) begin
				if (cfg.index == fcv_pkg::CFG_COEF_FIRST + fcv_pkg::CFG_INDEX_W'(k)) begin
					coef_q[k] <= $signed(cfg.data);
				end
			end
		end
	end

	// Issue control: a new sample or a zero tail step, gated by output credit.
	always_comb begin
		taps = fcv_pkg::taps_in_use(tap_count_q);
		in_tail = (tail_q != '0);
		room = (outst_q < CW'(fcv_pkg::OUT_DEPTH));
		issue = room && (in_tail || head_valid);
		head_pop = room && !in_tail && head_valid;
		cur = in_tail ? '0 : $signed(head.sample);
		blk_end = in_tail ? (tail_q == TW'(1)) : (head.last && (taps == TW'(1)));
		start_tail = !in_tail && head.last && (taps != TW'(1));
	end

	// Window and products of the active taps.
	always_comb begin
		window[0] = cur;
		for (int j = 1; j < NT; j++) begin
			window[j] = dl_q[j-1];
		end
		for (int j = 0; j < NT; j++) begin
			if (j < int'(taps)) begin
				prod[j] = coef_q[j] * window[j];
			end else begin
				prod[j] = '0;
			end
		end
	end

	// History and tail counter; the history clears after a block's final result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NT - 1; k++) begin
				dl_q[k] <= '0;
			end
			tail_q <= '0;
		end else if (issue) begin
			if (blk_end) begin
				for (int k = 0; k < NT - 1; k++) begin
					dl_q[k] <= '0;
				end
			end else begin
				dl_q[0] <= cur;
				for (int k = 1; k < NT - 1; k++) begin
					dl_q[k] <= dl_q[k-1];
				end
			end
			if (start_tail) begin
				tail_q <= taps - TW'(1);
			end else if (in_tail) begin
				tail_q <= tail_q - TW'(1);
			end
		end
	end

	// Results in flight or waiting in the output queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (issue && !out_pop) begin
			outst_q <= outst_q + 1'b1;
		end else if (out_pop && !issue) begin
			outst_q <= outst_q - 1'b1;
		end
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1 holds the products, stage 2 the pairwise sums.
	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		last_s1 <= blk_end;
		last_s2 <= last_s1;
		for (int h = 0; h < NH; h++) begin
			if (2 * h + 1 < NT) begin
				psum_s2[h] <= AW'(prod_s1[2*h]) + AW'(prod_s1[2*h+1]);
			end else begin
				psum_s2[h] <= AW'(prod_s1[2*h]);
			end
		end
	end

	// Final sum, wrapped to the result width.
	always_comb begin
		total = '0;
		for (int h = 0; h < NH; h++) begin
			total = total + psum_s2[h];
		end
		res_valid = valid_s2;
		res.value = total[fcv_pkg::RESULT_WIDTH-1:0];
		res.last = last_s2;
	end

endmodule

// ===== rtl/fcv_outq.sv =====
module fcv_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  fcv_pkg::res_t  wr_data,
	output logic           empty,
	input  logic           pop,
	output fcv_pkg::res_t  head
);

	fcv_pkg::res_t                    mem_q [fcv_pkg::OUT_DEPTH];
	logic [fcv_pkg::OUT_PTR_W-1:0]    wr_ptr_q;
	logic [fcv_pkg::OUT_PTR_W-1:0]    rd_ptr_q;
	logic [fcv_pkg::OUT_PTR_W:0]      count_q;
	logic                             rd_en;

	// The back end never writes without credit, so no full check is needed here.
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];
	assign rd_en = pop && !empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_valid) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_valid && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/full_linear_convolution.sv =====
// Streaming full linear convolution with up to six taps.
// Samples enter through a queue-style port: a transfer happens when push is
// high and full is low. Results leave the same way: while empty is low the
// oldest result sits on result/last_result and a transfer happens when pop is high.
// Configuration is written over cfg_valid/cfg_index/cfg_data (cfg_ready is always
// high): index 0 is tap_count, indexes 1 to 6 are coef_0 to coef_5; write only
// while the block is idle.
// A result passes the input queue, the product and pairwise-sum registers and
// the output queue. Throughput: one result per cycle while the output queue has
// room, set by a two-stage multiply and add pipeline. A sample marked last adds
// taps_in_use-1 tail results, one per cycle with room, while queued samples wait.
// Reset clears the coefficients, sets tap_count to 3, zeroes the history and
// empties both queues.
// When the receiver stalls, the 8-entry output queue absorbs results in flight,
// issue stops once it is committed, and the 4-entry input queue then fills
// and raises full.
module full_linear_convolution (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic signed [fcv_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                    last_sample,
	output logic                                    empty,
	input  logic                                    pop,
	output logic signed [fcv_pkg::RESULT_WIDTH-1:0] result,
	output logic                                    last_result,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [fcv_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  logic [fcv_pkg::CFG_DATA_W-1:0]          cfg_data
);

	fcv_pkg::item_t   in_item;
	fcv_pkg::item_t   head;
	logic             head_valid;
	logic             head_pop;
	fcv_pkg::cfg_wr_t cfg;
	logic             res_valid;
	fcv_pkg::res_t    res;
	fcv_pkg::res_t    out_head;
	logic             out_pop;

	// Port packing.
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;
	assign in_item.sample = sample;
	assign in_item.last = last_sample;
	assign out_pop = pop && !empty;
	assign result = out_head.value;
	assign last_result = out_head.last;

	fcv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (in_item),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	fcv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.out_pop    (out_pop),
		.res_valid  (res_valid),
		.res        (res)
	);

	fcv_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (res_valid),
		.wr_data  (res),
		.empty    (empty),
		.pop      (pop),
		.head     (out_head)
	);

endmodule

// ===== rtl/fcv_checker.sv =====
module fcv_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    push,
	input logic                                    full,
	input logic                                    last_sample,
	input logic                                    empty,
	input logic                                    pop,
	input logic signed [fcv_pkg::RESULT_WIDTH-1:0] result,
	input logic                                    last_result,
	input logic                                    cfg_valid,
	input logic                                    cfg_ready
);

	logic [31:0] lasts_in_q;
	logic [31:0] lasts_out_q;

	// Count block ends seen on each side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lasts_in_q <= '0;
			lasts_out_q <= '0;
		end else begin
			if (push && !full && last_sample) begin
				lasts_in_q <= lasts_in_q + 1'b1;
			end
			if (pop && !empty && last_result) begin
				lasts_out_q <= lasts_out_q + 1'b1;
			end
		end
	end

	// A waiting result stays put until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result) && $stable(last_result))
		else $error("result changed or vanished while stalled");

	// A block-end result only follows a block-end sample.
	a_last_order: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && last_result |-> (lasts_in_q - lasts_out_q) != '0)
		else $error("block-end result without a block-end sample");

	// Leaving reset, the block is empty and ready for input.
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty && !full)
		else $error("queues not clear after reset");

	// Configuration is always taken.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind full_linear_convolution fcv_checker u_fcv_checker (.*);

// ===== tb/tb_full_linear_convolution.sv =====
`timescale 1ns / 100ps

module tb_full_linear_convolution;

	import fcv_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PERCENT = 24;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 35;
	localparam logic [CFG_INDEX_W-1:0] UNMAPPED_INDEX = 3'd7;
	localparam logic [CFG_DATA_W-1:0] FULL_NEG = 16'h8000;
	localparam logic [CFG_DATA_W-1:0] FULL_POS = 16'h7FFF;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic last_sample;
	logic empty;
	logic pop;
	logic signed [RESULT_WIDTH-1:0] result;
	logic last_result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the filter configuration and sample history.
	logic [TAP_COUNT_WIDTH-1:0] tap_setting;
	logic signed [COEF_WIDTH-1:0] coef_q [COEF_REGS];
	logic signed [SAMPLE_WIDTH-1:0] history [MAX_TAPS-1];

	// Convolution outputs predicted but not yet transferred out.
	res_t pending_results [$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_cycles = 0;
	bit steady = 1'b0;

	full_linear_convolution uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.last_sample(last_sample),
		.empty(empty),
		.pop(pop),
		.result(result),
		.last_result(last_result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Free-running clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Number of taps the filter really uses for a given register value.
	function automatic int active_taps(input logic [TAP_COUNT_WIDTH-1:0] tc);
		if (tc == 0) begin
			return 1;
		end else if (int'(tc) > MAX_TAPS) begin
			return MAX_TAPS;
		end
		return int'(tc);
	endfunction

	// Weighted sum of the current sample and the history, wrapped to the result width.
	function automatic logic signed [RESULT_WIDTH-1:0] tap_sum(
		input logic signed [SAMPLE_WIDTH-1:0] current, input int taps);
		longint acc;
		acc = longint'(coef_q[0]) * longint'(current);
		for (int j = 1; j < taps; j++) begin
			acc += longint'(coef_q[j]) * longint'(history[j-1]);
		end
		return acc[RESULT_WIDTH-1:0];
	endfunction

	function automatic void shift_history(input logic signed [SAMPLE_WIDTH-1:0] s);
		for (int j = MAX_TAPS - 2; j > 0; j--) begin
			history[j] = history[j-1];
		end
		history[0] = s;
	endfunction

	// Queue the outputs one accepted sample causes, including the tail flush.
	function automatic void predict_convolution(input logic signed [SAMPLE_WIDTH-1:0] s,
		input logic is_last);
		int taps;
		res_t r;
		taps = active_taps(tap_setting);
		r.value = tap_sum(s, taps);
		r.last = is_last && (taps == 1);
		pending_results.push_back(r);
		shift_history(s);
		if (is_last) begin
			for (int k = 1; k < taps; k++) begin
				r.value = tap_sum('0, taps);
				r.last = (k == taps - 1);
				pending_results.push_back(r);
				shift_history('0);
			end
			for (int j = 0; j < MAX_TAPS - 1; j++) begin
				history[j] = '0;
			end
		end
	endfunction

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop = 1'b0;
		end else if (hold_cycles > 0) begin
			pop = 1'b0;
			hold_cycles--;
		end else begin
			pop = steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Compare every output transfer with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected output, expected none, got result %0d last %0b",
					$time, result, last_result);
				mismatch_count++;
			end else begin
				if (result !== pending_results[0].value) begin
					$display("%0t: result mismatch, expected %0d, got %0d",
						$time, pending_results[0].value, result);
					mismatch_count++;
				end
				if (last_result !== pending_results[0].last) begin
					$display("%0t: last_result mismatch, expected %0b, got %0b",
						$time, pending_results[0].last, last_result);
					mismatch_count++;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	// Offer one sample and hold it until the transfer happens.
	task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] s, input logic is_last);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		sample = s;
		last_sample = is_last;
		do @(posedge clk); while (full);
		predict_convolution(s, is_last);
	endtask

	// Stop offering samples and wait until all predicted outputs have transferred.
	task automatic wait_results_drained();
		@(negedge clk);
		push = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_TAP_COUNT) begin
			tap_setting = val[TAP_COUNT_WIDTH-1:0];
		end else if (idx >= CFG_COEF_FIRST && int'(idx) < int'(CFG_COEF_FIRST) + COEF_REGS) begin
			coef_q[idx - CFG_COEF_FIRST] = val;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Coefficient k sits in bits 16k+15 down to 16k of coefs.
	task automatic configure_filter(input logic [TAP_COUNT_WIDTH-1:0] taps,
		input logic [COEF_REGS*COEF_WIDTH-1:0] coefs);
		wait_results_drained();
		write_register(CFG_TAP_COUNT, CFG_DATA_W'(taps));
		for (int i = 0; i < COEF_REGS; i++) begin
			write_register(CFG_COEF_FIRST + CFG_INDEX_W'(i), coefs[COEF_WIDTH*i +: COEF_WIDTH]);
		end
	endtask

	// Full-scale values show up often so the sum extremes are reached.
	function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
		case ($urandom_range(7))
			0: return FULL_NEG;
			1: return FULL_POS;
			2: return '0;
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	function automatic logic [COEF_REGS*COEF_WIDTH-1:0] pick_coefs();
		logic [COEF_REGS*COEF_WIDTH-1:0] c;
		for (int i = 0; i < COEF_REGS; i++) begin
			c[COEF_WIDTH*i +: COEF_WIDTH] = pick_sample();
		end
		return c;
	endfunction

	task automatic send_block(input int len, input bit close);
		for (int i = 0; i < len; i++) begin
			send_sample(pick_sample(), close && (i == len - 1));
		end
	endtask

	// Reset values: zero coefficients first, then a three-tap filter.
	task automatic test_reset_state();
		send_sample(FULL_NEG, 1'b0);
		send_sample(FULL_POS, 1'b1);
		wait_results_drained();
		write_register(CFG_COEF_FIRST, 16'h1234);
		write_register(CFG_COEF_FIRST + 3'd1, FULL_NEG);
		write_register(CFG_COEF_FIRST + 3'd2, FULL_POS);
		write_register(CFG_COEF_FIRST + 3'd3, 16'h4000);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8001, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'hFFFF, 1'b1);
	endtask

	// Largest positive and negative sums with all six taps.
	task automatic test_full_scale_products();
		configure_filter(3'd6, {COEF_REGS{FULL_NEG}});
		for (int i = 0; i < 6; i++) begin
			send_sample(FULL_NEG, i == 5);
		end
		configure_filter(3'd6, {COEF_REGS{FULL_POS}});
		send_sample(FULL_NEG, 1'b0);
		send_sample(FULL_POS, 1'b0);
		send_sample(FULL_NEG, 1'b1);
	endtask

	// With one tap the last sample's own output carries the last mark.
	task automatic test_single_tap();
		configure_filter(3'd1, {{5{16'h0101}}, FULL_NEG});
		send_sample(FULL_POS, 1'b0);
		send_sample(FULL_NEG, 1'b1);
	endtask

	// Zero acts as one tap; seven clamps to six.
	task automatic test_tap_count_limits();
		configure_filter(3'd0, {16'h7001, 16'h6002, 16'h5003, 16'h4004, 16'h3005, 16'hC006});
		send_sample(16'h2AAA, 1'b1);
		configure_filter(3'd7, {16'h7001, 16'h6002, 16'h5003, 16'h4004, 16'h3005, 16'hC006});
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b1);
	endtask

	// A narrower tap count inside a block keeps the older history for later.
	task automatic test_tap_change_within_block();
		configure_filter(3'd5, {16'h0000, 16'h1111, 16'hE222, 16'h3333, 16'hC444, 16'h5555});
		send_sample(16'h1000, 1'b0);
		send_sample(16'hF000, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		wait_results_drained();
		write_register(CFG_TAP_COUNT, 16'd2);
		send_sample(16'h8000, 1'b0);
		wait_results_drained();
		write_register(CFG_TAP_COUNT, 16'd5);
		send_sample(16'h0123, 1'b1);
	endtask

	// A write to an index past the coefficients changes nothing.
	task automatic test_unmapped_index();
		wait_results_drained();
		write_register(UNMAPPED_INDEX, 16'hFFFF);
		send_sample(16'h4321, 1'b1);
	endtask

	// Receiver holds off long enough for the input side to report full.
	task automatic test_output_backpressure();
		configure_filter(3'd4, pick_coefs());
		steady = 1'b1;
		hold_cycles = 120;
		for (int b = 0; b < 5; b++) begin
			send_block(8, 1'b1);
		end
		wait_results_drained();
		steady = 1'b0;
	endtask

	// Sender goes quiet until every output has come, then resumes mid-stream.
	task automatic test_sender_pause();
		configure_filter(3'd3, pick_coefs());
		send_block(5, 1'b1);
		wait_results_drained();
		send_block(5, 1'b1);
	endtask

	// Random blocks under several settings; some phases end with a block left open.
	task automatic test_random_blocks();
		int sent;
		int len;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				configure_filter(3'd6, {COEF_REGS{FULL_POS}});
			end else if (p == RANDOM_PHASES - 1) begin
				configure_filter(3'd1, {COEF_REGS{FULL_NEG}});
			end else begin
				configure_filter(TAP_COUNT_WIDTH'($urandom_range(7)), pick_coefs());
			end
			steady = (p == 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = $urandom_range(1, 10);
				send_block(len, (sent + len < PHASE_ITEMS) || ($urandom_range(2) != 0));
				sent += len;
			end
		end
		wait_results_drained();
		steady = 1'b0;
	endtask

	// Reset, run each test in turn, then report.
	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		sample = '0;
		last_sample = 1'b0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tap_setting = TAP_COUNT_RESET;
		for (int i = 0; i < COEF_REGS; i++) begin
			coef_q[i] = '0;
		end
		for (int i = 0; i < MAX_TAPS - 1; i++) begin
			history[i] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_full_scale_products();
		test_single_tap();
		test_tap_count_limits();
		test_tap_change_within_block();
		test_unmapped_index();
		test_output_backpressure();
		test_sender_pause();
		test_random_blocks();
		wait_results_drained();

		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fcv_pkg.sv
rtl/fcv_front.sv
rtl/fcv_back.sv
rtl/fcv_outq.sv
rtl/full_linear_convolution.sv
rtl/fcv_checker.sv
tb/tb_full_linear_convolution.sv
